// ===== rtl/core/ffsa_pkg.sv =====
package ffsa_pkg;

   // Slots examined side by side, one lane memory each
   localparam int LANES  = 8;
   localparam int LANE_W = 3;

   // Result field widths
   localparam int KIND_W     = 2;
   localparam int IDX_OUT_W  = 6;
   localparam int MISS_W     = 16;
   localparam int RSP_DATA_W = 24;

   localparam logic [MISS_W-1:0] MISS_MAX = 16'hFFFF;

   typedef enum logic [KIND_W-1:0] {
      KIND_CLEAR = 2'd0,
      KIND_LOAD  = 2'd1,
      KIND_PLACE = 2'd2,
      KIND_SPARE = 2'd3
   } kind_type;

   typedef enum logic {
      ST_IDLE,
      ST_SCAN
   } state_type;

   // Controller to datapath
   typedef struct packed {
      logic clear;
      logic load;
      logic spare;
      logic miss;
      logic hit;
      logic scan_start;
      logic scan_step;
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic out_busy;
      logic empty;
      logic hit;
      logic last_miss;
   } status_type;

endpackage

// ===== rtl/core/ffsa_ctrl.sv =====
module ffsa_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   input  ffsa_pkg::kind_type    kind,
   input  ffsa_pkg::status_type  status,
   output logic                  req_tready,
   output ffsa_pkg::cmd_type     cmd
);

   ffsa_pkg::state_type state_ff, state_in;
   logic                accept;

   // Take a request only when idle and the result register can be reused
   assign req_tready = (state_ff == ffsa_pkg::ST_IDLE) && !status.out_busy;
   assign accept     = req_tvalid && req_tready;

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ffsa_pkg::ST_IDLE: begin
            if (accept && (kind == ffsa_pkg::KIND_PLACE) && !status.empty) begin
               state_in = ffsa_pkg::ST_SCAN;
            end
         end
         ffsa_pkg::ST_SCAN: begin
            if (status.hit || status.last_miss) begin
               state_in = ffsa_pkg::ST_IDLE;
            end
         end
         default: state_in = ffsa_pkg::ST_IDLE;
      endcase
   end

   // Commands
   always_comb begin
      cmd = '0;
      unique case (state_ff)
         ffsa_pkg::ST_IDLE: begin
            if (accept) begin
               unique case (kind)
                  ffsa_pkg::KIND_CLEAR: cmd.clear = 1'b1;
                  ffsa_pkg::KIND_LOAD:  cmd.load  = 1'b1;
                  ffsa_pkg::KIND_PLACE: begin
                     if (status.empty) begin
                        cmd.miss = 1'b1;
                     end else begin
                        cmd.scan_start = 1'b1;
                     end
                  end
                  ffsa_pkg::KIND_SPARE: cmd.spare = 1'b1;
                  default:              cmd.spare = 1'b1;
               endcase
            end
         end
         ffsa_pkg::ST_SCAN: begin
            cmd.scan_step = 1'b1;
            if (status.hit) begin
               cmd.hit = 1'b1;
            end else if (status.last_miss) begin
               cmd.miss = 1'b1;
            end
         end
         default: cmd = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ffsa_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== rtl/core/ffsa_datapath.sv =====
module ffsa_datapath #(
   parameter int SLOTS       = 64,
   parameter int AMOUNT_BITS = 30
) (
   input  logic                                clock,
   input  logic                                reset,
   input  ffsa_pkg::cmd_type                   cmd,
   output ffsa_pkg::status_type                status,
   input  logic [AMOUNT_BITS-1:0]              amount_in,
   input  logic                                rsp_tready,
   output logic                                rsp_tvalid,
   output logic [ffsa_pkg::RSP_DATA_W-1:0]     rsp_tdata
);

   localparam int LANES      = ffsa_pkg::LANES;
   localparam int LANE_W     = ffsa_pkg::LANE_W;
   localparam int ROWS       = (SLOTS + LANES - 1) / LANES;
   localparam int ROW_W      = (ROWS > 1) ? $clog2(ROWS) : 1;
   localparam int BANK_DEPTH = 1 << ROW_W;
   localparam int IW         = ROW_W + LANE_W;
   localparam int CNT_W      = $clog2(SLOTS + 1);
   localparam int CMP_W      = (IW > CNT_W) ? IW : CNT_W;
   localparam int MISS_W     = ffsa_pkg::MISS_W;
   localparam int IDX_OUT_W  = ffsa_pkg::IDX_OUT_W;

   logic [CNT_W-1:0]       loaded_ff, loaded_in;
   logic [MISS_W-1:0]      misses_ff, misses_in;
   logic [AMOUNT_BITS-1:0] amount_ff;
   logic [ROW_W-1:0]       row_ff, row_in;
   logic [ROW_W-1:0]       chk_row_ff;
   logic                   chk_valid_ff;

   logic [AMOUNT_BITS-1:0] lane_cap [LANES];
   logic [LANES-1:0]       lane_match;
   logic [LANE_W-1:0]      hit_lane;
   logic                   any_match;
   logic                   full;
   logic [IW-1:0]          load_idx;
   logic [IW-1:0]          last_idx;
   logic [ROW_W-1:0]       last_row;
   logic [IW-1:0]          hit_idx;

   logic [LANES-1:0]       wr_en;
   logic [ROW_W-1:0]       wr_row;
   logic [AMOUNT_BITS:0]   wr_data;

   logic                   emit;
   logic                   rsp_valid_ff;
   logic                   rsp_placed_ff;
   logic [IDX_OUT_W-1:0]   rsp_index_ff;
   logic [MISS_W-1:0]      rsp_miss_ff;
   logic                   rsp_ovf_ff;

   // Table fill bookkeeping
   assign full     = (loaded_ff == CNT_W'(SLOTS));
   assign load_idx = IW'(loaded_ff);
   assign last_idx = IW'(loaded_ff - CNT_W'(1));
   assign last_row = last_idx[IW-1:LANE_W];

   // One memory per lane; entry is {free mark, capacity}
   for (genvar l = 0; l < LANES; l++) begin : g_lane
      logic [AMOUNT_BITS:0] bank_mem [BANK_DEPTH];
      logic [AMOUNT_BITS:0] bank_rd_ff;
      logic [IW-1:0]        lane_idx;

      always_ff @(posedge clock) begin
         if (wr_en[l]) begin
            bank_mem[wr_row] <= wr_data;
         end
         bank_rd_ff <= bank_mem[row_ff];
      end

      assign lane_idx      = {chk_row_ff, LANE_W'(l)};
      assign lane_cap[l]   = bank_rd_ff[AMOUNT_BITS-1:0];
      assign lane_match[l] = chk_valid_ff
                             && (CMP_W'(lane_idx) < CMP_W'(loaded_ff))
                             && bank_rd_ff[AMOUNT_BITS]
                             && (bank_rd_ff[AMOUNT_BITS-1:0] >= amount_ff);
   end

   // Lowest matching lane of the row under check
   always_comb begin
      hit_lane = '0;
      for (int l = LANES - 1; l >= 0; l--) begin
         if (lane_match[l]) begin
            hit_lane = LANE_W'(l);
         end
      end
   end

   assign any_match = |lane_match;
   assign hit_idx   = {chk_row_ff, hit_lane};

   // Lane memory write: append on load, drop free mark on hit
   always_comb begin
      wr_en   = '0;
      wr_row  = load_idx[IW-1:LANE_W];
      wr_data = {1'b1, amount_in};
      if (cmd.load && !full) begin
         wr_en[load_idx[LANE_W-1:0]] = 1'b1;
      end else if (cmd.hit) begin
         wr_en[hit_lane] = 1'b1;
         wr_row          = chk_row_ff;
         wr_data         = {1'b0, lane_cap[hit_lane]};
      end
   end

   // Counters
   always_comb begin
      loaded_in = loaded_ff;
      misses_in = misses_ff;
      if (cmd.clear) begin
         loaded_in = '0;
         misses_in = '0;
      end else if (cmd.load && !full) begin
         loaded_in = loaded_ff + CNT_W'(1);
      end else if (cmd.miss && (misses_ff != ffsa_pkg::MISS_MAX)) begin
         misses_in = misses_ff + MISS_W'(1);
      end
   end

   // Row read pointer
   always_comb begin
      row_in = row_ff;
      if (cmd.scan_start) begin
         row_in = '0;
      end else if (cmd.scan_step) begin
         row_in = row_ff + ROW_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         loaded_ff    <= '0;
         misses_ff    <= '0;
         row_ff       <= '0;
         chk_valid_ff <= 1'b0;
      end else begin
         loaded_ff <= loaded_in;
         misses_ff <= misses_in;
         row_ff    <= row_in;
         if (cmd.scan_start) begin
            chk_valid_ff <= 1'b0;
         end else if (cmd.scan_step) begin
            chk_valid_ff <= 1'b1;
         end
      end
   end

   // Scan payload
   always_ff @(posedge clock) begin
      if (cmd.scan_start) begin
         amount_ff <= amount_in;
      end
      if (cmd.scan_step) begin
         chk_row_ff <= row_ff;
      end
   end

   // Result register
   assign emit = cmd.clear || cmd.load || cmd.spare || cmd.miss || cmd.hit;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_placed_ff <= cmd.hit;
         rsp_index_ff  <= cmd.hit ? IDX_OUT_W'(hit_idx) : '0;
         rsp_miss_ff   <= misses_in;
         rsp_ovf_ff    <= cmd.load && full;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_ovf_ff, rsp_miss_ff, rsp_index_ff, rsp_placed_ff};

   // Status
   assign status.out_busy  = rsp_valid_ff && !rsp_tready;
   assign status.empty     = (loaded_ff == '0);
   assign status.hit       = any_match;
   assign status.last_miss = chk_valid_ff && !any_match && (chk_row_ff == last_row);

endmodule

// ===== rtl/core/first_fit_slot_assigner_top.sv =====
// Channel   Direction  Ports                  Contents
// req       in         req_tvalid/tready      tuser: kind; tdata: amount
// rsp       out        rsp_tvalid/tready      tdata: placed, slot_index, miss_count, overflow
//
// Clear, load, unused kind and a place into an empty table: result registered
// at the accept edge, next request possible in the following cycle.
// Place: the lane memories are read one row of 8 slots per cycle, lowest row first;
// the result is registered when a row with a match is checked or the last row misses.
// Reset (synchronous) empties the table and zeroes the miss count.
// A stalled result holds the block: no request is taken until it can be replaced.
module first_fit_slot_assigner_top #(
   parameter int SLOTS       = 64,
   parameter int AMOUNT_BITS = 30
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_tvalid,
   output logic                                   req_tready,
   // [AMOUNT_BITS-1:0] amount, rest zero
   input  logic [((AMOUNT_BITS + 7) / 8) * 8-1:0] req_tdata,
   // [1:0] kind
   input  logic [ffsa_pkg::KIND_W-1:0]            req_tuser,
   output logic                                   rsp_tvalid,
   input  logic                                   rsp_tready,
   // [0] placed, [6:1] slot_index, [22:7] miss_count, [23] overflow
   output logic [ffsa_pkg::RSP_DATA_W-1:0]        rsp_tdata
);

   ffsa_pkg::cmd_type    cmd;
   ffsa_pkg::status_type status;
   ffsa_pkg::kind_type   kind;

   assign kind = ffsa_pkg::kind_type'(req_tuser);

   ffsa_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .kind       (kind),
      .status     (status),
      .req_tready (req_tready),
      .cmd        (cmd)
   );

   ffsa_datapath #(
      .SLOTS       (SLOTS),
      .AMOUNT_BITS (AMOUNT_BITS)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .amount_in  (req_tdata[AMOUNT_BITS-1:0]),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tdata  (rsp_tdata)
   );

`ifndef ASSERT_OFF
   // At most one action on the table per cycle
   a_one_action: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.clear, cmd.load, cmd.spare, cmd.miss, cmd.hit, cmd.scan_start}))
      else $error("more than one table action in a cycle");

   // A started search keeps further requests out
   a_scan_blocks: assert property (@(posedge clock) disable iff (reset)
      cmd.scan_start |=> !req_tready)
      else $error("request taken while searching");

   // The result register is free while a search runs
   a_scan_no_rsp: assert property (@(posedge clock) disable iff (reset)
      cmd.scan_start |=> !rsp_tvalid)
      else $error("stale result during search");

   // A placement and an overflow never share a result
   a_flags: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(rsp_tdata[0] && rsp_tdata[23]))
      else $error("placed and overflow both set");
`endif

endmodule
